// File: rtl/rth_pkg.sv
`timescale 1ns / 1ps
// Shared widths, codes and pipeline payload types for the RGB to HSV converter.
// No dependencies; every other file refers to this package by scoped names.
package rth_pkg;

	localparam int unsigned COLOR_BITS = 8;
	localparam int unsigned HUE_BITS   = 16;

	// 6*delta needs three bits more than a colour component.
	localparam int unsigned SIX_W      = COLOR_BITS + 3;
	localparam int unsigned DIV_STAGES = (HUE_BITS > COLOR_BITS) ? HUE_BITS : COLOR_BITS;

	typedef logic [COLOR_BITS-1:0] color_t;
	typedef logic [HUE_BITS-1:0]   hue_t;
	typedef logic [SIX_W-1:0]      six_t;

	typedef enum logic [1:0] {
		SECT_RED,
		SECT_GREEN,
		SECT_BLUE
	} sector_t;

	// After the comparison stage.
	typedef struct packed {
		color_t  red;
		color_t  green;
		color_t  blue;
		color_t  mx;
		color_t  delta;
		sector_t sector;
	} stage1_t;

	// Carried through the divider stages.
	typedef struct packed {
		six_t   hue_rem;
		six_t   hue_div;
		hue_t   hue_quo;
		color_t sat_rem;
		color_t sat_low;
		color_t sat_quo;
		color_t brightness;
		logic   grey;
	} div_t;

endpackage

// File: rtl/rth_if.sv
`timescale 1ns / 1ps
// Valid/ready stream interfaces for pixels in (RGB) and results out (HSV).
// Depends on rth_pkg for the field widths.
interface rth_pix_if;
	logic            valid;
	logic            ready;
	rth_pkg::color_t red;
	rth_pkg::color_t green;
	rth_pkg::color_t blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rth_hsv_if;
	logic            valid;
	logic            ready;
	rth_pkg::hue_t   hue_turn;
	logic            hue_valid;
	rth_pkg::color_t saturation;
	rth_pkg::color_t brightness;

	modport source (output valid, output hue_turn, output hue_valid, output saturation,
		output brightness, input ready);
	modport sink   (input valid, input hue_turn, input hue_valid, input saturation,
		input brightness, output ready);
endinterface

// File: rtl/rth_prep.sv
`timescale 1ns / 1ps
// Front end of the converter: maximum, minimum and sector, then the divider operands.
// Depends on rth_pkg and rth_pix_if.
module rth_prep (
	input  logic          clk,
	input  logic          arst_n,
	rth_pix_if.sink       pix,
	output logic          div_valid,
	input  logic          div_ready,
	output rth_pkg::div_t div_data
);

	localparam int unsigned CB = rth_pkg::COLOR_BITS;
	localparam int unsigned SW = rth_pkg::SIX_W;

	logic             valid_s1, valid_s2;
	logic             rdy1, rdy2;
	rth_pkg::stage1_t nxt1, data_s1;
	rth_pkg::div_t    nxt2, data_s2;

	logic [SW:0]      nn, d_ext;
	rth_pkg::six_t    six;
	logic [2*CB-1:0]  sat_num;
	rth_pkg::color_t  mn;

	assign rdy2      = !valid_s2 || div_ready;
	assign rdy1      = !valid_s1 || rdy2;
	assign pix.ready = rdy1;
	assign div_valid = valid_s2;
	assign div_data  = data_s2;

	// Stage 1: red wins a tie for the maximum, then green.
	always_comb begin
		nxt1.red   = pix.red;
		nxt1.green = pix.green;
		nxt1.blue  = pix.blue;
		if (pix.red >= pix.green && pix.red >= pix.blue) begin
			nxt1.sector = rth_pkg::SECT_RED;
			nxt1.mx     = pix.red;
		end else if (pix.green >= pix.blue) begin
			nxt1.sector = rth_pkg::SECT_GREEN;
			nxt1.mx     = pix.green;
		end else begin
			nxt1.sector = rth_pkg::SECT_BLUE;
			nxt1.mx     = pix.blue;
		end
		mn = pix.red;
		if (pix.green < mn) mn = pix.green;
		if (pix.blue < mn) mn = pix.blue;
		nxt1.delta = nxt1.mx - mn;
	end

	// Stage 2: hue numerator folded into 0..6*delta-1, and delta*(2^CB-1) for saturation.
	always_comb begin
		d_ext = {{(SW+1-CB){1'b0}}, data_s1.delta};
		six   = SW'((d_ext << 2) + (d_ext << 1));
		case (data_s1.sector)
			rth_pkg::SECT_RED: begin
				nn = {{(SW+1-CB){1'b0}}, data_s1.green} - {{(SW+1-CB){1'b0}}, data_s1.blue};
				if (nn[SW]) nn = nn + {1'b0, six};
			end
			rth_pkg::SECT_GREEN: begin
				nn = (d_ext << 1) + {{(SW+1-CB){1'b0}}, data_s1.blue}
					- {{(SW+1-CB){1'b0}}, data_s1.red};
			end
			rth_pkg::SECT_BLUE: begin
				nn = (d_ext << 2) + {{(SW+1-CB){1'b0}}, data_s1.red}
					- {{(SW+1-CB){1'b0}}, data_s1.green};
			end
			default: begin
				nn = '0;
			end
		endcase
		sat_num         = ({{CB{1'b0}}, data_s1.delta} << CB) - {{CB{1'b0}}, data_s1.delta};
		nxt2.hue_rem    = nn[SW-1:0];
		nxt2.hue_div    = six;
		nxt2.hue_quo    = '0;
		nxt2.sat_rem    = sat_num[2*CB-1:CB];
		nxt2.sat_low    = sat_num[CB-1:0];
		nxt2.sat_quo    = '0;
		nxt2.brightness = data_s1.mx;
		nxt2.grey       = (data_s1.delta == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= pix.valid;
			if (rdy2) valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1 && pix.valid) data_s1 <= nxt1;
		if (rdy2 && valid_s1) data_s2 <= nxt2;
	end

	// The hue remainder must start below its divisor, or the quotient overflows.
	a_hue_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !data_s2.grey |-> data_s2.hue_rem < data_s2.hue_div)
		else $error("hue numerator out of range");

	a_sat_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && data_s2.brightness != '0 |-> data_s2.sat_rem < data_s2.brightness)
		else $error("saturation numerator out of range");

endmodule

// File: rtl/rth_div.sv
`timescale 1ns / 1ps
// Pipelined restoring dividers for hue and saturation, one quotient bit per stage.
// Depends on rth_pkg and rth_hsv_if; the last stage is the output register.
module rth_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rth_pkg::div_t in_data,
	rth_hsv_if.source     hsv
);

	localparam int unsigned NS = rth_pkg::DIV_STAGES;
	localparam int unsigned CB = rth_pkg::COLOR_BITS;
	localparam int unsigned HB = rth_pkg::HUE_BITS;
	localparam int unsigned SW = rth_pkg::SIX_W;

	rth_pkg::div_t src_data [0:NS];
	logic          src_valid [0:NS];
	logic          rdy [0:NS];
	rth_pkg::div_t pipe_data_s [0:NS-1];
	logic          pipe_valid_s [0:NS-1];

	assign src_data[0]  = in_data;
	assign src_valid[0] = in_valid;
	assign rdy[NS]      = hsv.ready;
	assign in_ready     = rdy[0];

	genvar k;
	generate
		for (k = 0; k < NS; k++) begin : g_stage
			logic [SW:0]   ht;
			logic          hb;
			logic [CB:0]   st;
			logic          sb;
			rth_pkg::div_t nxt;

			assign rdy[k]         = !pipe_valid_s[k] || rdy[k+1];
			assign src_data[k+1]  = pipe_data_s[k];
			assign src_valid[k+1] = pipe_valid_s[k];

			always_comb begin
				nxt = src_data[k];
				ht  = '0;
				hb  = 1'b0;
				st  = '0;
				sb  = 1'b0;
				if (k < HB) begin
					ht = {src_data[k].hue_rem, 1'b0};
					if (ht >= {1'b0, src_data[k].hue_div}) begin
						ht = ht - {1'b0, src_data[k].hue_div};
						hb = 1'b1;
					end
					nxt.hue_rem = ht[SW-1:0];
					nxt.hue_quo = {src_data[k].hue_quo[HB-2:0], hb};
				end
				if (k < CB) begin
					st = {src_data[k].sat_rem, src_data[k].sat_low[CB-1]};
					if (st >= {1'b0, src_data[k].brightness}) begin
						st = st - {1'b0, src_data[k].brightness};
						sb = 1'b1;
					end
					nxt.sat_rem = st[CB-1:0];
					nxt.sat_low = {src_data[k].sat_low[CB-2:0], 1'b0};
					nxt.sat_quo = {src_data[k].sat_quo[CB-2:0], sb};
				end
			end

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					pipe_valid_s[k] <= 1'b0;
				end else if (rdy[k]) begin
					pipe_valid_s[k] <= src_valid[k];
				end
			end

			always_ff @(posedge clk) begin
				if (rdy[k] && src_valid[k]) pipe_data_s[k] <= nxt;
			end
		end
	endgenerate

	// A zero divisor drives the quotients to all ones, so grey and black are masked here.
	assign hsv.valid      = pipe_valid_s[NS-1];
	assign hsv.hue_valid  = !pipe_data_s[NS-1].grey;
	assign hsv.hue_turn   = pipe_data_s[NS-1].grey ? '0 : pipe_data_s[NS-1].hue_quo;
	assign hsv.saturation = (pipe_data_s[NS-1].brightness == '0) ? '0
		: pipe_data_s[NS-1].sat_quo;
	assign hsv.brightness = pipe_data_s[NS-1].brightness;

	a_black_is_grey: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid && hsv.brightness == '0 |-> !hsv.hue_valid && hsv.saturation == '0)
		else $error("black pixel not reported as grey");

	// Any nonzero delta gives delta*(2^CB-1) >= max, so saturation is at least one.
	a_colour_saturated: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid && hsv.hue_valid |-> hsv.saturation != '0)
		else $error("coloured pixel with zero saturation");

	a_grey_hue_zero: assert property (@(posedge clk) disable iff (!arst_n)
		hsv.valid && !hsv.hue_valid |-> hsv.hue_turn == '0)
		else $error("grey pixel with nonzero hue");

endmodule

// File: rtl/rgb_to_hsv.sv
`timescale 1ns / 1ps
// Top level of the RGB to HSV converter: comparison front end and divider pipeline.
// Depends on rth_pkg, rth_if (rth_pix_if, rth_hsv_if), rth_prep and rth_div.
//
//   port  direction  fields                                          role
//   pix   sink       red, green, blue                                pixel in
//   hsv   source     hue_turn, hue_valid, saturation, brightness     result out
//
// One pixel is taken in every cycle while the result side is ready, and passes through DIV_STAGES + 2
// register stages: the comparison and operand stages of the front end, then the divider stages,
// each of which produces one bit of the hue quotient.
// Reset clears only the stage valid bits; no clearing pass is needed.
// Every stage holds its contents while the next one is full and stalled, and an empty
// stage takes data regardless, so bubbles close up behind a held result.
module rgb_to_hsv (
	input  logic      clk,
	input  logic      arst_n,
	rth_pix_if.sink   pix,
	rth_hsv_if.source hsv
);

	logic          div_valid;
	logic          div_ready;
	rth_pkg::div_t div_data;

	rth_prep u_prep (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix       (pix),
		.div_valid (div_valid),
		.div_ready (div_ready),
		.div_data  (div_data)
	);

	rth_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.in_ready (div_ready),
		.in_data  (div_data),
		.hsv      (hsv)
	);

endmodule

// File: verif/rgb_to_hsv_tb.sv
`timescale 1ns / 1ps
// Self-checking RGB to HSV testbench: directed, random, back-pressure and streaming tests.
// Depends on rth_pkg, the rth_pix_if and rth_hsv_if interfaces and the rgb_to_hsv top level.
module rgb_to_hsv_tb;

	localparam int unsigned COLOR_MAX   = (1 << rth_pkg::COLOR_BITS) - 1;
	localparam int unsigned DRAIN_WAIT  = rth_pkg::DIV_STAGES + 20;
	localparam int unsigned HOLD_CYCLES = 200;
	localparam int unsigned CYCLE_LIMIT = 200000;

	typedef struct packed {
		rth_pkg::hue_t   hue_turn;
		logic            hue_valid;
		rth_pkg::color_t saturation;
		rth_pkg::color_t brightness;
	} hsv_result_t;

	logic clk;
	logic arst_n;

	rth_pix_if pix_bus ();
	rth_hsv_if hsv_bus ();

	rgb_to_hsv i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.pix    (pix_bus),
		.hsv    (hsv_bus)
	);

	hsv_result_t hsv_expected[$];
	int unsigned mismatch_count = 0;
	int unsigned cycle_count    = 0;
	bit          src_idle       = 1'b0;
	bit          snk_idle       = 1'b0;
	bit          hold_req       = 1'b0;

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** rgb_to_hsv: FAILED **");
			$finish;
		end
	end

	// Expected HSV of one pixel, in integer fixed point.
	function automatic hsv_result_t predict_hsv(rth_pkg::color_t r, rth_pkg::color_t g,
		rth_pkg::color_t b);
		hsv_result_t       res;
		rth_pkg::color_t   mx;
		rth_pkg::color_t   mn;
		int unsigned       delta;
		int unsigned       six;
		int                n;
		rth_pkg::sector_t  sect;
		longint unsigned   scaled;
		res = '0;
		mx  = r;
		mn  = r;
		if (g > mx) mx = g;
		if (b > mx) mx = b;
		if (g < mn) mn = g;
		if (b < mn) mn = b;
		delta = int'(mx) - int'(mn);
		// Red wins a tie for the maximum, then green.
		if (r == mx)
			sect = rth_pkg::SECT_RED;
		else if (g == mx)
			sect = rth_pkg::SECT_GREEN;
		else
			sect = rth_pkg::SECT_BLUE;
		res.brightness = mx;
		if (mx != 0)
			res.saturation = rth_pkg::color_t'((delta * COLOR_MAX) / mx);
		if (delta != 0) begin
			six = 6 * delta;
			case (sect)
				rth_pkg::SECT_RED:   n = int'(g) - int'(b);
				rth_pkg::SECT_GREEN: n = 2 * int'(delta) + int'(b) - int'(r);
				default:             n = 4 * int'(delta) + int'(r) - int'(g);
			endcase
			if (n < 0) n += int'(six);
			if (n >= int'(six)) n -= int'(six);
			scaled = longint'(n) << rth_pkg::HUE_BITS;
			res.hue_turn  = rth_pkg::hue_t'(scaled / six);
			res.hue_valid = 1'b1;
		end
		return res;
	endfunction

	// Every pixel transfer queues its expected result.
	always @(posedge clk) begin
		if (pix_bus.valid === 1'b1 && pix_bus.ready === 1'b1)
			hsv_expected.push_back(predict_hsv(pix_bus.red, pix_bus.green, pix_bus.blue));
	end

	always @(posedge clk) begin
		hsv_result_t exp_res;
		if (hsv_bus.valid === 1'b1 && hsv_bus.ready === 1'b1) begin
			if (hsv_expected.size() == 0) begin
				$error("unexpected result transfer: hue_turn %0d brightness %0d",
					hsv_bus.hue_turn, hsv_bus.brightness);
				mismatch_count++;
			end else begin
				exp_res = hsv_expected.pop_front();
				if (hsv_bus.hue_turn !== exp_res.hue_turn) begin
					$error("hue_turn: expected %0d, got %0d", exp_res.hue_turn, hsv_bus.hue_turn);
					mismatch_count++;
				end
				if (hsv_bus.hue_valid !== exp_res.hue_valid) begin
					$error("hue_valid: expected %0d, got %0d", exp_res.hue_valid,
						hsv_bus.hue_valid);
					mismatch_count++;
				end
				if (hsv_bus.saturation !== exp_res.saturation) begin
					$error("saturation: expected %0d, got %0d", exp_res.saturation,
						hsv_bus.saturation);
					mismatch_count++;
				end
				if (hsv_bus.brightness !== exp_res.brightness) begin
					$error("brightness: expected %0d, got %0d", exp_res.brightness,
						hsv_bus.brightness);
					mismatch_count++;
				end
			end
		end
	end

	// Result side: random stalls, and one long hold-off when the pressure test asks for it.
	initial begin
		int unsigned stall;
		int unsigned held;
		hsv_bus.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hsv_bus.ready <= 1'b0;
				held = 0;
				while (held < HOLD_CYCLES) begin
					@(negedge clk);
					held++;
				end
				hsv_bus.ready <= 1'b1;
				hold_req = 1'b0;
			end else if (snk_idle && $urandom_range(0, 4) == 0) begin
				stall = $urandom_range(1, 11);
				hsv_bus.ready <= 1'b0;
				repeat (stall) @(negedge clk);
				hsv_bus.ready <= 1'b1;
			end else begin
				hsv_bus.ready <= 1'b1;
			end
		end
	end

	// Offers one pixel and returns once it has been transferred.
	task automatic send_pixel(input rth_pkg::color_t r, input rth_pkg::color_t g,
		input rth_pkg::color_t b);
		@(negedge clk);
		if (src_idle && $urandom_range(0, 4) == 0) begin
			pix_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 11)) @(negedge clk);
		end
		pix_bus.valid <= 1'b1;
		pix_bus.red   <= r;
		pix_bus.green <= g;
		pix_bus.blue  <= b;
		do
			@(posedge clk);
		while (pix_bus.ready !== 1'b1);
	endtask

	// Random pixel, weighted towards greys, pairs of equal components, tiny components and near-full ones.
	task automatic send_random_pixel();
		rth_pkg::color_t r;
		rth_pkg::color_t g;
		rth_pkg::color_t b;
		rth_pkg::color_t v;
		r = rth_pkg::color_t'($urandom);
		g = rth_pkg::color_t'($urandom);
		b = rth_pkg::color_t'($urandom);
		v = rth_pkg::color_t'($urandom);
		case ($urandom_range(0, 9))
			0: begin
				r = v;
				g = v;
				b = v;
			end
			1: begin
				case ($urandom_range(0, 2))
					0: g = r;
					1: b = r;
					default: b = g;
				endcase
			end
			2: begin
				r = rth_pkg::color_t'($urandom_range(0, 3));
				g = rth_pkg::color_t'($urandom_range(0, 3));
				b = rth_pkg::color_t'($urandom_range(0, 3));
			end
			3: begin
				r = rth_pkg::color_t'(COLOR_MAX - $urandom_range(0, 2));
				g = rth_pkg::color_t'(COLOR_MAX - $urandom_range(0, 2));
				b = rth_pkg::color_t'(COLOR_MAX - $urandom_range(0, 2));
			end
			default: ;
		endcase
		send_pixel(r, g, b);
	endtask

	task automatic test_directed();
		send_pixel(8'd0, 8'd0, 8'd0);
		send_pixel(8'd255, 8'd255, 8'd255);
		send_pixel(8'd128, 8'd128, 8'd128);
		send_pixel(8'd255, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd255);
		send_pixel(8'd255, 8'd255, 8'd0);
		send_pixel(8'd0, 8'd255, 8'd255);
		send_pixel(8'd255, 8'd0, 8'd255);
		// Red maximum with blue above green wraps round to just below a full turn.
		send_pixel(8'd255, 8'd0, 8'd1);
		send_pixel(8'd1, 8'd0, 8'd0);
		send_pixel(8'd0, 8'd1, 8'd0);
		send_pixel(8'd0, 8'd0, 8'd1);
		send_pixel(8'd255, 8'd254, 8'd254);
		send_pixel(8'd254, 8'd255, 8'd255);
		send_pixel(8'd1, 8'd1, 8'd0);
		send_pixel(8'd170, 8'd85, 8'd255);
	endtask

	task automatic test_random_traffic();
		src_idle = 1'b1;
		snk_idle = 1'b1;
		repeat (500) send_random_pixel();
	endtask

	task automatic test_backpressure();
		src_idle = 1'b0;
		snk_idle = 1'b0;
		hold_req = 1'b1;
		// The results are held back far longer than the pipeline can absorb.
		repeat (60) send_random_pixel();
		while (hold_req) @(posedge clk);
	endtask

	task automatic test_streaming();
		src_idle = 1'b0;
		snk_idle = 1'b0;
		repeat (280) send_random_pixel();
	endtask

	initial begin
		arst_n        = 1'b0;
		pix_bus.valid = 1'b0;
		pix_bus.red   = '0;
		pix_bus.green = '0;
		pix_bus.blue  = '0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_random_traffic();
		test_backpressure();
		test_streaming();

		@(negedge clk);
		pix_bus.valid <= 1'b0;
		while (hsv_expected.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (mismatch_count == 0) begin
			$display("** rgb_to_hsv: PASSED **");
		end else begin
			$display("** rgb_to_hsv: FAILED **");
		end
		$finish;
	end

endmodule
